// ===== design/lpkv_pkg.sv =====
// Package for the linear probing key/value table: request kinds, status codes,
// slot marks and the queue entry type shared by the front end and the probe engine.
// No dependencies.
package lpkv_pkg;

	// Number of slots; a power of two, so the home slot is the low bits of the hash.
	localparam int TABLE_DEPTH = 256;

	typedef enum logic [1:0] {
		KIND_GET = 2'd0,
		KIND_PUT = 2'd1,
		KIND_DEL = 2'd2,
		KIND_BAD = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_MISSING = 2'd1,
		ST_FULL    = 2'd2,
		ST_SPARE   = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		MARK_EMPTY   = 2'd0,
		MARK_FILLED  = 2'd1,
		MARK_DELETED = 2'd2,
		MARK_SPARE   = 2'd3
	} mark_t;

	// One classified request: canonical key and value plus the full DJB2 hash.
	typedef struct packed {
		kind_t       kind;
		logic [63:0] key;
		logic [63:0] value;
		logic [63:0] hash;
	} req_t;

	// Clear bytes past the first zero byte or past nbytes.
	function automatic logic [63:0] canon_bytes(input logic [63:0] x, input int nbytes);
		logic [63:0] r;
		logic        stop;
		r    = '0;
		stop = 1'b0;
		for (int i = 0; i < 8; i++) begin
			if (i >= nbytes || x[8*i +: 8] == 8'd0)
				stop = 1'b1;
			if (!stop)
				r[8*i +: 8] = x[8*i +: 8];
		end
		return r;
	endfunction

endpackage

// ===== design/lpkv_front.sv =====
// Front end: canonicalizes key and value and hashes the key one byte per cycle.
// Depends on lpkv_pkg.
module lpkv_front
	import lpkv_pkg::*;
#(
	parameter int KEY_BYTES   = 8,
	parameter int VALUE_BYTES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  in_kind,
	input  logic [63:0] in_key,
	input  logic [63:0] in_value,
	output logic        req_valid,
	input  logic        req_ready,
	output req_t        req
);

	typedef enum logic [1:0] {F_IDLE, F_HASH, F_DONE} fstate_t;

	fstate_t     state_q;
	req_t        req_q;
	logic [2:0]  byte_q;

	assign in_ready  = (state_q == F_IDLE);
	assign req_valid = (state_q == F_DONE);
	assign req       = req_q;

	// Hash walk: h = h*33 + byte while bytes are nonzero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			byte_q  <= '0;
		end else begin
			unique case (state_q)
				F_IDLE: begin
					if (in_valid) begin
						req_q.kind  <= kind_t'(in_kind);
						req_q.key   <= canon_bytes(in_key, KEY_BYTES);
						req_q.value <= canon_bytes(in_value, VALUE_BYTES);
						req_q.hash  <= 64'd5381;
						byte_q      <= '0;
						state_q     <= F_HASH;
					end
				end
				F_HASH: begin
					if (req_q.key[{byte_q, 3'b000} +: 8] == 8'd0) begin
						state_q <= F_DONE;
					end else begin
						req_q.hash <= (req_q.hash << 5) + req_q.hash
							+ {56'd0, req_q.key[{byte_q, 3'b000} +: 8]};
						byte_q <= byte_q + 3'd1;
						if (byte_q == 3'd7)
							state_q <= F_DONE;
					end
				end
				F_DONE: begin
					if (req_ready)
						state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

// ===== design/lpkv_queue.sv =====
// Two-entry request queue between the front end and the probe engine.
// Depends on lpkv_pkg.
module lpkv_queue
	import lpkv_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic wr_valid,
	output logic wr_ready,
	input  req_t wr_data,
	output logic rd_valid,
	input  logic rd_ready,
	output req_t rd_data
);

	req_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign wr_ready = (cnt_q != 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_data  = mem_q[rp_q];
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wp_q] <= wr_data;
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
		end
	end

endmodule

// ===== design/lpkv_engine.sv =====
// Probe engine: walks the slots linearly, updates slot memories and counters,
// and holds the result register. Depends on lpkv_pkg.
module lpkv_engine
	import lpkv_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  req_t        req,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [1:0]  res_status,
	output logic [63:0] res_found,
	output logic [8:0]  res_entries,
	output logic [31:0] res_ops,
	output logic [31:0] res_colls,
	output logic [7:0]  res_longest
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam int CW = IW + 1;

	typedef enum logic [2:0] {E_IDLE, E_CLEAR, E_READ, E_WAIT, E_EVAL, E_OUT} estate_t;

	estate_t        state_q;
	logic [63:0]    keys_q  [TABLE_DEPTH];
	logic [63:0]    vals_q  [TABLE_DEPTH];
	logic [1:0]     marks_q [TABLE_DEPTH];
	logic [63:0]    rkey_q, rval_q;
	logic [1:0]     rmark_q;
	req_t           cur_q;
	logic [IW-1:0]  idx_q;
	logic [CW-1:0]  off_q;
	logic [CW-1:0]  filled_q;
	logic [31:0]    ops_q, colls_q;
	logic [7:0]     longest_q;
	logic           out_q;
	logic [1:0]     stat_q;
	logic [63:0]    found_q;
	// Memory write port.
	logic           we;
	logic [1:0]     wmark;
	logic           wkv;
	logic           match;
	logic [63:0]    home;

	assign req_ready   = (state_q == E_IDLE);
	assign res_valid   = out_q;
	assign res_status  = stat_q;
	assign res_found   = found_q;
	assign res_entries = 9'(filled_q);
	assign res_ops     = ops_q;
	assign res_colls   = colls_q;
	assign res_longest = longest_q;
	assign match       = (rmark_q == MARK_FILLED) && (rkey_q == cur_q.key);
	assign home        = req.hash % TABLE_DEPTH;

	// Decide memory writes in the clearing pass and the evaluate step.
	always_comb begin
		we    = 1'b0;
		wmark = MARK_FILLED;
		wkv   = 1'b0;
		if (state_q == E_CLEAR) begin
			we    = 1'b1;
			wmark = MARK_EMPTY;
		end else if (state_q == E_EVAL) begin
			if (cur_q.kind == KIND_PUT && rmark_q != MARK_FILLED) begin
				we  = 1'b1;
				wkv = 1'b1;
			end else if (cur_q.kind == KIND_PUT && match) begin
				we  = 1'b1;
				wkv = 1'b1;
			end else if (cur_q.kind == KIND_DEL && match) begin
				we    = 1'b1;
				wmark = MARK_DELETED;
			end
		end
	end

	// Slot memories with registered reads.
	always_ff @(posedge clk) begin
		if (we) begin
			marks_q[idx_q] <= wmark;
			if (wkv) begin
				keys_q[idx_q] <= cur_q.key;
				vals_q[idx_q] <= cur_q.value;
			end
		end
		rmark_q <= marks_q[idx_q];
		rkey_q  <= keys_q[idx_q];
		rval_q  <= vals_q[idx_q];
	end

	// Request latch.
	always_ff @(posedge clk) begin
		if (state_q == E_IDLE && req_valid)
			cur_q <= req;
	end

	// Sequencer: clearing pass, then read, wait, evaluate per probe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= E_CLEAR;
			idx_q     <= '0;
			off_q     <= '0;
			filled_q  <= '0;
			ops_q     <= '0;
			colls_q   <= '0;
			longest_q <= '0;
			out_q     <= 1'b0;
			stat_q    <= ST_OK;
			found_q   <= '0;
		end else begin
			unique case (state_q)
				E_CLEAR: begin
					idx_q <= idx_q + 1'b1;
					if (idx_q == IW'(TABLE_DEPTH - 1))
						state_q <= E_IDLE;
				end
				E_IDLE: begin
					if (req_valid) begin
						idx_q <= IW'(home);
						off_q <= '0;
						if (req.kind == KIND_BAD) begin
							stat_q  <= ST_MISSING;
							found_q <= '0;
							out_q   <= 1'b1;
							state_q <= E_OUT;
						end else begin
							ops_q   <= ops_q + 32'd1;
							state_q <= E_READ;
						end
					end
				end
				E_READ: state_q <= E_WAIT;
				E_WAIT: begin
					state_q <= E_EVAL;
					if (off_q != '0) begin
						colls_q <= colls_q + 32'd1;
						if (off_q > CW'(longest_q))
							longest_q <= (off_q > CW'(255)) ? 8'd255 : 8'(off_q);
					end
				end
				E_EVAL: begin
					found_q <= '0;
					if (cur_q.kind == KIND_PUT && (rmark_q != MARK_FILLED || match)) begin
						if (rmark_q != MARK_FILLED)
							filled_q <= filled_q + 1'b1;
						stat_q  <= ST_OK;
						out_q   <= 1'b1;
						state_q <= E_OUT;
					end else if (cur_q.kind != KIND_PUT && rmark_q == MARK_EMPTY) begin
						stat_q  <= ST_MISSING;
						out_q   <= 1'b1;
						state_q <= E_OUT;
					end else if (cur_q.kind != KIND_PUT && match) begin
						if (cur_q.kind == KIND_GET)
							found_q <= rval_q;
						else
							filled_q <= filled_q - 1'b1;
						stat_q  <= ST_OK;
						out_q   <= 1'b1;
						state_q <= E_OUT;
					end else if (off_q == CW'(TABLE_DEPTH - 1)) begin
						stat_q  <= (cur_q.kind == KIND_PUT) ? ST_FULL : ST_MISSING;
						out_q   <= 1'b1;
						state_q <= E_OUT;
					end else begin
						off_q   <= off_q + 1'b1;
						idx_q   <= idx_q + 1'b1;
						state_q <= E_READ;
					end
				end
				E_OUT: begin
					if (res_ready) begin
						out_q   <= 1'b0;
						state_q <= E_IDLE;
					end
				end
				default: state_q <= E_IDLE;
			endcase
		end
	end

endmodule

// ===== design/linear_probe_kv_table.sv =====
// Top level of the linear probing key/value table.
// Depends on lpkv_pkg, lpkv_front, lpkv_queue and lpkv_engine.
//
// Requests arrive on the s_axis channel: tuser carries the kind (get, put,
// delete), tdata the key and the value. Each request gives exactly one result
// transaction on m_axis: status in tuser, found value and counters in tdata.
// The front end canonicalizes the key and hashes it one byte per cycle; a
// two-entry queue lets it take the next request while the probe engine works.
// For each slot visited, from one up to TABLE_DEPTH slots per request, the
// probe engine does a memory read, registers the data, then evaluates it.
// After reset a clearing pass marks all slots empty, one per cycle; requests
// are hashed and queued but not probed meanwhile.
// When the receiver stalls, the result holds in its register and the engine
// waits; the front end and queue keep accepting until the queue fills.
module linear_probe_kv_table
	import lpkv_pkg::*;
#(
	parameter int KEY_BYTES   = 8,
	parameter int VALUE_BYTES = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	input  logic [127:0] s_axis_tdata,  // key [63:0], value [127:64]
	input  logic [1:0]   s_axis_tuser,  // kind [1:0]
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// found_value [63:0], entry_count [72:64], operation_total [104:73],
	// collision_total [136:105], longest_probe [144:137], zero fill [151:145]
	output logic [151:0] m_axis_tdata,
	output logic [1:0]   m_axis_tuser   // status [1:0]
);

	req_t        f_req, q_req;
	logic        f_valid, f_ready, q_valid, q_ready;
	logic [63:0] found;
	logic [8:0]  entries;
	logic [31:0] ops, colls;
	logic [7:0]  longest;

	lpkv_front #(.KEY_BYTES(KEY_BYTES), .VALUE_BYTES(VALUE_BYTES)) u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
		.in_kind(s_axis_tuser), .in_key(s_axis_tdata[63:0]),
		.in_value(s_axis_tdata[127:64]),
		.req_valid(f_valid), .req_ready(f_ready), .req(f_req)
	);

	lpkv_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_req),
		.rd_valid(q_valid), .rd_ready(q_ready), .rd_data(q_req)
	);

	lpkv_engine u_engine (
		.clk(clk), .arst_n(arst_n),
		.req_valid(q_valid), .req_ready(q_ready), .req(q_req),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
		.res_status(m_axis_tuser), .res_found(found), .res_entries(entries),
		.res_ops(ops), .res_colls(colls), .res_longest(longest)
	);

	assign m_axis_tdata = {7'd0, longest, colls, ops, entries, found};

	// A failing status never carries a value.
	a_found_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser != ST_OK |-> found == 64'd0)
		else $error("nonzero value with failing status");

	// The request counter moves by at most one per cycle.
	a_ops_step: assert property (@(posedge clk) disable iff (!arst_n)
		ops == $past(ops) || ops == $past(ops) + 32'd1)
		else $error("request counter jumped");

	// The longest probe never decreases.
	a_longest_mono: assert property (@(posedge clk) disable iff (!arst_n)
		longest >= $past(longest))
		else $error("longest probe decreased");

endmodule
